@@ hdl/bur_pkg.sv @@
// ----------------------------------------------------------------------------
// bur_pkg
// Shared types, constants and helper functions of the bounded uniform
// random sampler: twister geometry, micro-operation codes and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bur_pkg;

    // Twister geometry.
    localparam int unsigned TW_N = 312;
    localparam int unsigned TW_M = 156;
    localparam int unsigned IDX_W = 9;

    localparam logic [IDX_W-1:0] IDX_N    = IDX_W'(TW_N);
    localparam logic [IDX_W-1:0] IDX_M    = IDX_W'(TW_M);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TW_N - 1);

    // Twister constants.
    localparam logic [63:0] TW_MATRIX   = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] TW_UPPER    = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] TW_LOWER    = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] TW_INIT_MUL = 64'd6364136223846793005;
    localparam logic [63:0] RESET_SEED  = 64'h9e37_79b9_7f4a_7c15;

    // Splitmix64 constants.
    localparam logic [63:0] MIX_ADD  = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_MUL1 = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL2 = 64'h94d0_49bb_1331_11eb;

    // Reset value of the bound register.
    localparam logic [63:0] BOUND_RESET = 64'd6;

    // Request modes.
    localparam logic [1:0] MODE_DRAW     = 2'd0;
    localparam logic [1:0] MODE_MIX_SEED = 2'd1;
    localparam logic [1:0] MODE_RAW_SEED = 2'd2;

    // Datapath micro-operations.
    typedef logic [4:0] op_t;
    localparam op_t OP_NOP       = 5'd0;
    localparam op_t OP_MIX_A     = 5'd1;
    localparam op_t OP_MIX_B     = 5'd2;
    localparam op_t OP_MIX_END   = 5'd3;
    localparam op_t OP_MUL       = 5'd4;
    localparam op_t OP_SD_INIT   = 5'd5;
    localparam op_t OP_SD_PREP   = 5'd6;
    localparam op_t OP_SD_STORE  = 5'd7;
    localparam op_t OP_RG_START  = 5'd8;
    localparam op_t OP_RG_A      = 5'd9;
    localparam op_t OP_RG_B      = 5'd10;
    localparam op_t OP_RG_C      = 5'd11;
    localparam op_t OP_RG_D      = 5'd12;
    localparam op_t OP_DR_RD     = 5'd13;
    localparam op_t OP_DR_TMP    = 5'd14;
    localparam op_t OP_DIV_START = 5'd15;
    localparam op_t OP_DIV       = 5'd16;
    localparam op_t OP_OUT_HI    = 5'd17;
    localparam op_t OP_OUT_ZERO  = 5'd18;

    // Controller to datapath.
    typedef struct packed {
        op_t  op;
        logic in_ready;
    } bur_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_mode;
        logic       bound_zero;
        logic       pos_wrap;
        logic       idx_last;
        logic       mul_done;
        logic       lo_lt_n;
        logic       lo_lt_t;
        logic       div_done;
        logic       out_free;
    } bur_status_t;

    // Output tempering of one twister word.
    function automatic logic [63:0] tw_temper(input logic [63:0] w);
        logic [63:0] y;
        begin
            y = w;
            y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
            y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
            y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
            y = y ^ (y >> 43);
            return y;
        end
    endfunction

endpackage

@@ hdl/bur_if.sv @@
// ----------------------------------------------------------------------------
// bur_if
// Valid/ready channel interfaces of the sampler: request, result and
// bound configuration.
// ----------------------------------------------------------------------------
interface bur_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] seed_value;

    modport source (output valid, output mode, output seed_value, input ready);
    modport sink (input valid, input mode, input seed_value, output ready);
endinterface

interface bur_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface bur_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] bound;

    modport source (output valid, output bound, input ready);
    modport sink (input valid, input bound, output ready);
endinterface

@@ hdl/bur_ram.sv @@
// ----------------------------------------------------------------------------
// bur_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bur_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 312
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/bur_datapath.sv @@
// ----------------------------------------------------------------------------
// bur_datapath
// Datapath of the sampler: twister word store, shared 32x32 multiplier
// with a 128-bit accumulator, bit-serial remainder unit, bound register
// and the result register.
// ----------------------------------------------------------------------------
module bur_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bur_pkg::bur_cmd_t    cmd,
    output bur_pkg::bur_status_t st,
    bur_req_if.sink              req,
    bur_rsp_if.source            rsp,
    bur_cfg_if.sink              cfg
);
    import bur_pkg::*;

    // Control registers.
    logic [63:0]      bound_reg, bound_next;
    logic [63:0]      w_reg, w_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [2:0]       mcnt_reg, mcnt_next;
    logic [6:0]       dcnt_reg, dcnt_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers.
    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  p_reg, p_next;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  dq_reg, dq_next;
    logic [63:0]  out_value_reg, out_value_next;

    // Memory port signals.
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [63:0]      wdata;
    logic [IDX_W-1:0] raddr;
    logic [63:0]      rdata;

    // Helper values.
    logic [63:0]      acc_lo;
    logic [63:0]      acc_hi;
    logic [IDX_W-1:0] idx_nb;
    logic [IDX_W-1:0] idx_mid;
    logic [63:0]      y_mix;
    logic [63:0]      regen_word;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [127:0]     p_shift;
    logic [64:0]      rem_shift;
    logic             in_take;
    logic             out_take;

    assign acc_lo  = acc_reg[63:0];
    assign acc_hi  = acc_reg[127:64];
    assign idx_nb  = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign idx_mid = (idx_reg < IDX_M) ? idx_reg + IDX_M : idx_reg - IDX_M;

    // Twister recurrence for one word, the far word arriving from memory.
    assign y_mix      = (a_reg & TW_UPPER) | (b_reg & TW_LOWER);
    assign regen_word = rdata ^ (y_mix >> 1) ^ (y_mix[0] ? TW_MATRIX : 64'd0);

    // Partial product selection for the shared multiplier.
    assign mul_a = mcnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign mul_b = mcnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    // Alignment of the product taken in the previous cycle.
    always_comb
    begin
        unique case (mcnt_reg)
            3'd1:    p_shift = {64'd0, p_reg};
            3'd2,
            3'd3:    p_shift = {32'd0, p_reg, 32'd0};
            3'd4:    p_shift = {p_reg, 64'd0};
            default: p_shift = '0;
        endcase
    end

    assign rem_shift = {rem_reg, dq_reg[63]};

    assign in_take  = req.valid && cmd.in_ready;
    assign out_take = out_valid_reg && rsp.ready;

    // Handshake outputs.
    assign req.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.value = out_value_reg;

    // Status to the controller.
    assign st.in_valid   = req.valid;
    assign st.in_mode    = req.mode;
    assign st.bound_zero = (bound_reg == 64'd0);
    assign st.pos_wrap   = (pos_reg >= IDX_N);
    assign st.idx_last   = (idx_reg == IDX_LAST);
    assign st.mul_done   = (mcnt_reg == 3'd5);
    assign st.lo_lt_n    = (acc_lo < bound_reg);
    assign st.lo_lt_t    = (acc_lo < rem_reg);
    assign st.div_done   = (dcnt_reg == 7'd64);
    assign st.out_free   = !out_valid_reg || rsp.ready;

    // Next-state logic of all datapath registers.
    always_comb
    begin
        bound_next     = cfg.valid ? cfg.bound : bound_reg;
        w_next         = w_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        mcnt_next      = mcnt_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        p_next         = p_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        out_value_next = out_value_reg;
        we             = 1'b0;
        waddr          = idx_reg;
        wdata          = w_reg;
        raddr          = '0;

        // A taken request loads its seed, pre-offset for splitmix64 in mode 1.
        if (in_take)
        begin
            w_next = (req.mode == MODE_MIX_SEED) ? req.seed_value + MIX_ADD
                                                 : req.seed_value;
        end

        unique case (cmd.op)
            OP_MIX_A:
            begin
                a_next    = w_reg ^ (w_reg >> 30);
                b_next    = MIX_MUL1;
                acc_next  = '0;
                mcnt_next = '0;
            end
            OP_MIX_B:
            begin
                a_next    = acc_lo ^ (acc_lo >> 27);
                b_next    = MIX_MUL2;
                acc_next  = '0;
                mcnt_next = '0;
            end
            OP_MIX_END:
            begin
                w_next = acc_lo ^ (acc_lo >> 31);
            end
            OP_MUL:
            begin
                if (mcnt_reg < 3'd4)
                begin
                    p_next = 64'(mul_a) * 64'(mul_b);
                end
                acc_next  = acc_reg + p_shift;
                mcnt_next = mcnt_reg + 3'd1;
            end
            OP_SD_INIT:
            begin
                we       = 1'b1;
                waddr    = '0;
                wdata    = w_reg;
                idx_next = IDX_W'(1);
                pos_next = IDX_N;
            end
            OP_SD_PREP:
            begin
                a_next    = w_reg ^ (w_reg >> 62);
                b_next    = TW_INIT_MUL;
                acc_next  = '0;
                mcnt_next = '0;
            end
            OP_SD_STORE:
            begin
                w_next   = acc_lo + {{(64 - IDX_W){1'b0}}, idx_reg};
                we       = 1'b1;
                waddr    = idx_reg;
                wdata    = acc_lo + {{(64 - IDX_W){1'b0}}, idx_reg};
                idx_next = idx_reg + 1'b1;
                pos_next = IDX_N;
            end
            OP_RG_START:
            begin
                idx_next = '0;
            end
            OP_RG_A:
            begin
                raddr = idx_reg;
            end
            OP_RG_B:
            begin
                a_next = rdata;
                raddr  = idx_nb;
            end
            OP_RG_C:
            begin
                b_next = rdata;
                raddr  = idx_mid;
            end
            OP_RG_D:
            begin
                we       = 1'b1;
                waddr    = idx_reg;
                wdata    = regen_word;
                idx_next = idx_reg + 1'b1;
                pos_next = '0;
            end
            OP_DR_RD:
            begin
                raddr = pos_reg;
            end
            OP_DR_TMP:
            begin
                a_next    = tw_temper(rdata);
                b_next    = bound_reg;
                pos_next  = pos_reg + 1'b1;
                acc_next  = '0;
                mcnt_next = '0;
            end
            OP_DIV_START:
            begin
                rem_next  = '0;
                dq_next   = 64'd0 - bound_reg;
                dcnt_next = '0;
            end
            OP_DIV:
            begin
                // One restoring step of (2^64 - bound) mod bound.
                if (rem_shift >= {1'b0, bound_reg})
                begin
                    rem_next = 64'(rem_shift - {1'b0, bound_reg});
                end
                else
                begin
                    rem_next = rem_shift[63:0];
                end
                dq_next   = dq_reg << 1;
                dcnt_next = dcnt_reg + 7'd1;
            end
            OP_OUT_HI:
            begin
                out_value_next = acc_hi;
                out_valid_next = 1'b1;
            end
            OP_OUT_ZERO:
            begin
                out_value_next = '0;
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg     <= BOUND_RESET;
            w_reg         <= RESET_SEED;
            pos_reg       <= IDX_N;
            idx_reg       <= '0;
            mcnt_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bound_reg     <= bound_next;
            w_reg         <= w_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            mcnt_reg      <= mcnt_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        acc_reg       <= acc_next;
        p_reg         <= p_next;
        rem_reg       <= rem_next;
        dq_reg        <= dq_next;
        out_value_reg <= out_value_next;
    end

    // Twister word store.
    bur_ram #(
        .WIDTH (64),
        .DEPTH (TW_N)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Memory addresses stay inside the store.
    a_raddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        raddr < IDX_N) else $error("read address out of range");
    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> waddr < IDX_N) else $error("write address out of range");
    // A twister word is only read when the position is inside the block.
    a_pos_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_DR_RD |-> pos_reg < IDX_N) else $error("stale position read");

endmodule

@@ hdl/bur_ctrl.sv @@
// ----------------------------------------------------------------------------
// bur_ctrl
// Controller of the sampler: sequences seeding, splitmix64 mixing, block
// regeneration, multiply-high, rejection and result delivery.
// ----------------------------------------------------------------------------
module bur_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bur_pkg::bur_status_t st,
    output bur_pkg::bur_cmd_t    cmd
);
    import bur_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MIX0    = 4'd1;
    localparam logic [3:0] S_MIX1    = 4'd2;
    localparam logic [3:0] S_MIX2    = 4'd3;
    localparam logic [3:0] S_SD_INIT = 4'd4;
    localparam logic [3:0] S_SD_PREP = 4'd5;
    localparam logic [3:0] S_SD_MUL  = 4'd6;
    localparam logic [3:0] S_DR_CHK  = 4'd7;
    localparam logic [3:0] S_DR_TMP  = 4'd8;
    localparam logic [3:0] S_DR_MUL  = 4'd9;
    localparam logic [3:0] S_DR_TST  = 4'd10;
    localparam logic [3:0] S_DIV     = 4'd11;
    localparam logic [3:0] S_OUT     = 4'd12;
    localparam logic [3:0] S_RG_A    = 4'd13;
    localparam logic [3:0] S_RG_B    = 4'd14;
    localparam logic [3:0] S_RG_D    = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       draw_reg, draw_next;
    logic       rg_c_reg, rg_c_next;

    // State transitions and command decode.
    always_comb
    begin
        state_next   = state_reg;
        draw_next    = draw_reg;
        rg_c_next    = rg_c_reg;
        cmd.op       = OP_NOP;
        cmd.in_ready = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (st.in_valid)
                begin
                    if (st.in_mode == MODE_MIX_SEED)
                    begin
                        draw_next  = 1'b1;
                        state_next = S_MIX0;
                    end
                    else if (st.in_mode == MODE_RAW_SEED)
                    begin
                        draw_next  = 1'b0;
                        state_next = S_SD_INIT;
                    end
                    else
                    begin
                        state_next = S_DR_CHK;
                    end
                end
            end
            S_MIX0:
            begin
                cmd.op     = OP_MIX_A;
                state_next = S_MIX1;
            end
            S_MIX1:
            begin
                cmd.op = st.mul_done ? OP_MIX_B : OP_MUL;
                if (st.mul_done)
                begin
                    state_next = S_MIX2;
                end
            end
            S_MIX2:
            begin
                cmd.op = st.mul_done ? OP_MIX_END : OP_MUL;
                if (st.mul_done)
                begin
                    state_next = S_SD_INIT;
                end
            end
            S_SD_INIT:
            begin
                cmd.op     = OP_SD_INIT;
                state_next = S_SD_PREP;
            end
            S_SD_PREP:
            begin
                cmd.op     = OP_SD_PREP;
                state_next = S_SD_MUL;
            end
            S_SD_MUL:
            begin
                cmd.op = st.mul_done ? OP_SD_STORE : OP_MUL;
                if (st.mul_done)
                begin
                    if (!st.idx_last)
                    begin
                        state_next = S_SD_PREP;
                    end
                    else if (draw_reg)
                    begin
                        state_next = S_DR_CHK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DR_CHK:
            begin
                if (st.bound_zero)
                begin
                    state_next = S_OUT;
                end
                else if (st.pos_wrap)
                begin
                    cmd.op     = OP_RG_START;
                    state_next = S_RG_A;
                end
                else
                begin
                    cmd.op     = OP_DR_RD;
                    state_next = S_DR_TMP;
                end
            end
            S_DR_TMP:
            begin
                cmd.op     = OP_DR_TMP;
                state_next = S_DR_MUL;
            end
            S_DR_MUL:
            begin
                if (st.mul_done)
                begin
                    state_next = S_DR_TST;
                end
                else
                begin
                    cmd.op = OP_MUL;
                end
            end
            S_DR_TST:
            begin
                if (st.lo_lt_n)
                begin
                    cmd.op     = OP_DIV_START;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (!st.div_done)
                begin
                    cmd.op = OP_DIV;
                end
                else if (st.lo_lt_t)
                begin
                    state_next = S_DR_CHK;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = st.bound_zero ? OP_OUT_ZERO : OP_OUT_HI;
                    state_next = S_IDLE;
                end
            end
            S_RG_A:
            begin
                cmd.op     = OP_RG_A;
                rg_c_next  = 1'b0;
                state_next = S_RG_B;
            end
            S_RG_B:
            begin
                // OP_RG_B and then OP_RG_C here: first the near word, then the next word.
                cmd.op    = rg_c_reg ? OP_RG_C : OP_RG_B;
                rg_c_next = 1'b1;
                if (rg_c_reg)
                begin
                    state_next = S_RG_D;
                end
            end
            S_RG_D:
            begin
                cmd.op     = OP_RG_D;
                state_next = st.idx_last ? S_DR_CHK : S_RG_A;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Reset starts with seeding the twister from the default seed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SD_INIT;
            draw_reg  <= 1'b0;
            rg_c_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            draw_reg  <= draw_next;
            rg_c_reg  <= rg_c_next;
        end
    end

    // A result that can be stored returns the controller to idle.
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && st.out_free) |=> state_reg == S_IDLE)
        else $error("result not followed by idle");
    // The multiplier is never stepped past its last partial product.
    a_mul_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_MUL |-> !st.mul_done) else $error("multiplier overrun");
    // A raw reseed request starts seeding at once.
    a_raw_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.in_ready && st.in_valid && st.in_mode == MODE_RAW_SEED)
        |=> state_reg == S_SD_INIT) else $error("raw reseed not started");

endmodule

@@ hdl/bounded_uniform_random_sampler.sv @@
// ----------------------------------------------------------------------------
// bounded_uniform_random_sampler
// Unbiased bounded random samples from a 64-bit Mersenne Twister using
// multiply-high with rejection.
// ----------------------------------------------------------------------------
// Usage:
//   req carries mode and seed_value. Mode 0 (and 3) draws a sample, mode 1
//   reseeds through splitmix64 and then draws, mode 2 reseeds with the raw
//   seed and returns no transfer on rsp. rsp carries value in 0..bound-1,
//   or 0 when bound is 0. cfg writes the bound; write it only while idle.
//   One request is in work at a time; req.ready is high only when idle.
//   A plain draw reads a word from memory, tempers it and forms four
//   32x32 partial products on the shared multiplier. Once all 312 words
//   of the block are drawn, the next draw first regenerates it word by
//   word. A rare rejection test may add a bit-serial remainder and a redraw.
//   A reseed writes all 312 words in turn through the shared multiplier;
//   mode 1 mixes first. After reset the twister is seeded from the default
//   seed before the first request is taken. A result waits in the
//   output register while rsp is stalled; a new request is taken then,
//   but its result is held until the earlier one is transferred.
// ----------------------------------------------------------------------------
module bounded_uniform_random_sampler (
    input logic       clk,
    input logic       rst_n,
    bur_req_if.sink   req,
    bur_rsp_if.source rsp,
    bur_cfg_if.sink   cfg
);
    import bur_pkg::*;

    bur_cmd_t    cmd;
    bur_status_t st;

    // Sequencer.
    bur_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // Arithmetic, storage and channel registers.
    bur_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .st    (st),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

endmodule
